// ===== hw/rtl/ldpc_scaled_min_sum_decoder_defines.svh =====
// assertion macros for the min-sum decoder
`ifndef LDPC_SCALED_MIN_SUM_DECODER_DEFINES_SVH
`define LDPC_SCALED_MIN_SUM_DECODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LSMD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsmd same-cycle check failed");

// next-cycle implication, checked outside reset
`define LSMD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsmd next-cycle check failed");

`endif

// ===== hw/rtl/lsmd_pkg.sv =====
// types, constants and helpers of the min-sum decoder
`timescale 1ns / 1ps
`default_nettype none
package lsmd_pkg;
  localparam int N_MAX    = 128;
  localparam int M_MAX    = 64;
  localparam int LLR_BITS = 8;
  localparam int MSG_BITS = 8;
  localparam int APP_BITS = 12;
  localparam int COL_W    = $clog2(N_MAX);
  localparam int ROW_W    = $clog2(M_MAX);
  localparam int Q_W      = APP_BITS + 1;
  localparam int ACC_W    = 16;

  localparam logic [MSG_BITS-2:0] MSG_MAX_MAG = '1;
  localparam logic [Q_W-1:0] MAG_CLAMP = Q_W'(1 << (APP_BITS - 1));

  // input item kinds
  localparam logic MODE_MATRIX = 1'b0;
  localparam logic MODE_LLR    = 1'b1;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_MATRIX    = 2'd1,
    ST_LEN_MISMATCH = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CFG_CODE_LENGTH = 3'd0,
    CFG_CHECK_COUNT = 3'd1,
    CFG_MAX_ITER    = 3'd2,
    CFG_SCALE       = 3'd3,
    CFG_EARLY_STOP  = 3'd4,
    CFG_SCHEDULE    = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAT_WR,
    S_INIT,
    S_ROW_P1,
    S_ROW_P2,
    S_COL,
    S_SYN,
    S_ITER_END,
    S_HARD,
    S_EMIT
  } state_t;

  // saturate a wide sum to the posterior range
  function automatic logic signed [APP_BITS-1:0] sat_app(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'((1 << (APP_BITS - 1)) - 1);
    lo = -ACC_W'(1 << (APP_BITS - 1));
    if (v > hi) return hi[APP_BITS-1:0];
    if (v < lo) return lo[APP_BITS-1:0];
    return v[APP_BITS-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/ldpc_scaled_min_sum_decoder.sv =====
// a matrix word is taken in S_IDLE and written in S_MAT_WR, an llr word is taken in S_IDLE;
// the last llr starts a decode (init, then per iteration the row passes, the column pass
// when flooding and the syndrome check when early stop is on, then hard decisions), then
// ceil(n/32) result words; every step of the shared check/variable unit is a memory read,
// then an update; one codeword is decoded at a time, input is held off meanwhile; synchronous
// active-low reset clears control, config and matrix row valid flags, no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none
`include "ldpc_scaled_min_sum_decoder_defines.svh"
module ldpc_scaled_min_sum_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // row[5:0], column[12:6], h_bit[13], llr_value[21:14], zero[23:22]
  input  wire logic [23:0] in_tdata,
  // mode[0]
  input  wire logic        in_tuser,
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // word_index[1:0], hard_bits[33:2], iterations_used[39:34], converged[40],
  // status[42:41], zero[47:43]
  output logic [47:0]      out_tdata,
  output logic             out_tlast
);
  import lsmd_pkg::*;

  // configuration registers
  logic [7:0] code_length_r;
  logic [6:0] check_count_r;
  logic [5:0] max_iter_r;
  logic [4:0] scale_cfg_r;
  logic       early_stop_r;
  logic       schedule_r;

  // memories
  logic [N_MAX-1:0]          row_mem [M_MAX];
  logic [M_MAX-1:0]          row_vld_r;
  logic [LLR_BITS-1:0]       llr_mem [N_MAX];
  logic [APP_BITS-1:0]       app_mem [N_MAX];
  logic [MSG_BITS-1:0]       msg_mem [M_MAX*N_MAX];
  logic [N_MAX-1:0]          row_q;
  logic signed [LLR_BITS-1:0] llr_q;
  logic signed [APP_BITS-1:0] app_q;
  logic signed [MSG_BITS-1:0] msg_q;

  // sequencer state
  state_t state_r, state_nxt;
  logic ph_r, ph_nxt;
  logic [ROW_W-1:0] i_r, i_nxt;
  logic [COL_W-1:0] j_r, j_nxt;
  logic [1:0] k_r, k_nxt;
  logic [5:0] iter_r, iter_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] n_r, n_nxt;
  logic [6:0] m_r, m_nxt;
  logic [2:0] nw_r, nw_nxt;
  logic [4:0] scale_r, scale_nxt;
  logic [5:0] lim_r, lim_nxt;
  logic conv_r, conv_nxt;
  status_t status_r, status_nxt;
  logic [Q_W-1:0] min1_r, min1_nxt, min2_r, min2_nxt;
  logic have1_r, have1_nxt, have2_r, have2_nxt;
  logic [COL_W-1:0] idx_r, idx_nxt;
  logic neg_r, neg_nxt, par_r, par_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [N_MAX-1:0] hard_r, hard_nxt;
  logic [ROW_W-1:0] mrow_r, mrow_nxt;
  logic [COL_W-1:0] mcol_r, mcol_nxt;
  logic mbit_r, mbit_nxt;

  // memory write controls
  logic row_we, app_we, msg_we, llr_we;
  logic [N_MAX-1:0] row_wdata;
  logic signed [APP_BITS-1:0] app_wdata;
  logic signed [MSG_BITS-1:0] msg_wdata;
  logic [ROW_W-1:0] row_ra;

  // datapath of the shared check unit
  logic h, last_j, last_i, in_acc;
  logic signed [MSG_BITS-1:0] r_s, msg_new;
  logic signed [Q_W-1:0] q;
  logic [Q_W-1:0] qmag, selmag, magc;
  logic selhave, sgn;
  logic [17:0] prod, rnd;
  logic [MSG_BITS-2:0] mmag;
  logic signed [ACC_W-1:0] acc_new, addend;
  logic [7:0] cnt_inc, n_clamp;
  logic [8:0] nw_sum;
  status_t status_new;
  logic syn_bad;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_length_r <= 8'd128;
      check_count_r <= 7'd0;
      max_iter_r    <= 6'd20;
      scale_cfg_r   <= 5'd12;
      early_stop_r  <= 1'b1;
      schedule_r    <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CODE_LENGTH: code_length_r <= cfg_data;
        CFG_CHECK_COUNT: check_count_r <= cfg_data[6:0];
        CFG_MAX_ITER:    max_iter_r    <= cfg_data[5:0];
        CFG_SCALE:       scale_cfg_r   <= cfg_data[4:0];
        CFG_EARLY_STOP:  early_stop_r  <= cfg_data[0];
        CFG_SCHEDULE:    schedule_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // memory ports, read data registered
  assign row_ra = (state_r == S_IDLE) ? in_tdata[5:0] : i_r;
  always_ff @(posedge clk) begin
    row_q <= row_vld_r[row_ra] ? row_mem[row_ra] : '0;
    llr_q <= llr_mem[j_r];
    app_q <= app_mem[j_r];
    msg_q <= msg_mem[{i_r, j_r}];
    if (row_we) row_mem[mrow_r] <= row_wdata;
    if (llr_we) llr_mem[cnt_r[COL_W-1:0]] <= in_tdata[21:14];
    if (app_we) app_mem[j_r] <= app_wdata;
    if (msg_we) msg_mem[{i_r, j_r}] <= msg_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) row_vld_r <= '0;
    else if (row_we) row_vld_r[mrow_r] <= 1'b1;
  end

  // check unit: extrinsic value, scaled minimum, saturation
  always_comb begin
    h       = row_q[j_r];
    last_j  = ({1'b0, j_r} == n_r - 8'd1);
    last_i  = ({1'b0, i_r} == m_r - 7'd1);
    r_s     = (iter_r == 6'd0) ? '0 : msg_q;
    q       = Q_W'(app_q) - Q_W'(r_s);
    qmag    = q[Q_W-1] ? Q_W'(-q) : Q_W'(q);
    selmag  = (j_r == idx_r) ? min2_r : min1_r;
    selhave = (j_r == idx_r) ? have2_r : have1_r;
    magc    = (selmag > MAG_CLAMP) ? MAG_CLAMP : selmag;
    prod    = 18'(scale_r) * 18'(magc);
    rnd     = 18'(prod + 18'd8) >> 4;
    mmag    = (rnd > 18'(MSG_MAX_MAG)) ? MSG_MAX_MAG : rnd[MSG_BITS-2:0];
    sgn     = neg_r ^ q[Q_W-1];
    if (!selhave) msg_new = $signed({1'b0, MSG_MAX_MAG});
    else if (sgn) msg_new = -$signed({1'b0, mmag});
    else          msg_new = $signed({1'b0, mmag});
    addend  = h ? ACC_W'(msg_q) : '0;
    acc_new = ((i_r == '0) ? ACC_W'(llr_q) : acc_r) + addend;
    syn_bad = par_r ^ (h & app_q[APP_BITS-1]);
    // item acceptance helpers
    in_acc  = in_tvalid && in_tready;
    cnt_inc = (cnt_r == 8'd255) ? cnt_r : cnt_r + 8'd1;
    if (code_length_r == 8'd0) n_clamp = 8'd1;
    else if (code_length_r > 8'(N_MAX)) n_clamp = 8'(N_MAX);
    else n_clamp = code_length_r;
    nw_sum  = {1'b0, n_clamp} + 9'd31;
    if (check_count_r == 7'd0) status_new = ST_NO_MATRIX;
    else if (code_length_r == 8'd0 || code_length_r > 8'(N_MAX) ||
             cnt_inc != code_length_r) status_new = ST_LEN_MISMATCH;
    else status_new = ST_OK;
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r    <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      iter_r  <= '0;
      cnt_r   <= '0;
      conv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      iter_r  <= iter_nxt;
      cnt_r   <= cnt_nxt;
      conv_r  <= conv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    m_r      <= m_nxt;
    nw_r     <= nw_nxt;
    scale_r  <= scale_nxt;
    lim_r    <= lim_nxt;
    status_r <= status_nxt;
    min1_r   <= min1_nxt;
    min2_r   <= min2_nxt;
    have1_r  <= have1_nxt;
    have2_r  <= have2_nxt;
    idx_r    <= idx_nxt;
    neg_r    <= neg_nxt;
    par_r    <= par_nxt;
    acc_r    <= acc_nxt;
    hard_r   <= hard_nxt;
    mrow_r   <= mrow_nxt;
    mcol_r   <= mcol_nxt;
    mbit_r   <= mbit_nxt;
  end

  // next state and controls
  always_comb begin
    state_nxt = state_r;   ph_nxt = ph_r;     i_nxt = i_r;     j_nxt = j_r;
    k_nxt = k_r;           iter_nxt = iter_r; cnt_nxt = cnt_r; conv_nxt = conv_r;
    n_nxt = n_r;           m_nxt = m_r;       nw_nxt = nw_r;   scale_nxt = scale_r;
    lim_nxt = lim_r;       status_nxt = status_r;
    min1_nxt = min1_r;     min2_nxt = min2_r; have1_nxt = have1_r; have2_nxt = have2_r;
    idx_nxt = idx_r;       neg_nxt = neg_r;   par_nxt = par_r; acc_nxt = acc_r;
    hard_nxt = hard_r;     mrow_nxt = mrow_r; mcol_nxt = mcol_r; mbit_nxt = mbit_r;
    row_we = 1'b0; app_we = 1'b0; msg_we = 1'b0; llr_we = 1'b0;
    row_wdata = row_q;
    row_wdata[mcol_r] = mbit_r;
    app_wdata = sat_app(ACC_W'(q) + ACC_W'(msg_new));
    msg_wdata = msg_new;
    in_tready  = (state_r == S_IDLE);
    out_tvalid = (state_r == S_EMIT);
    case (state_r)
      S_IDLE: begin
        ph_nxt = 1'b0;
        if (in_acc && in_tuser == MODE_MATRIX) begin
          mrow_nxt  = in_tdata[5:0];
          mcol_nxt  = in_tdata[12:6];
          mbit_nxt  = in_tdata[13];
          state_nxt = S_MAT_WR;
        end else if (in_acc) begin
          llr_we  = (cnt_r < 8'(N_MAX));
          cnt_nxt = cnt_inc;
          if (in_tlast) begin
            cnt_nxt    = '0;
            n_nxt      = n_clamp;
            nw_nxt     = nw_sum[7:5];
            m_nxt      = (check_count_r > 7'(M_MAX)) ? 7'(M_MAX) : check_count_r;
            if (scale_cfg_r < 5'd2) scale_nxt = 5'd2;
            else if (scale_cfg_r > 5'd16) scale_nxt = 5'd16;
            else scale_nxt = scale_cfg_r;
            lim_nxt    = (max_iter_r == 6'd0) ? 6'd1 : max_iter_r;
            status_nxt = status_new;
            iter_nxt   = '0;
            conv_nxt   = 1'b0;
            hard_nxt   = '0;
            i_nxt      = '0;
            j_nxt      = '0;
            k_nxt      = '0;
            state_nxt  = (status_new == ST_OK) ? S_INIT : S_EMIT;
          end
        end
      end
      S_MAT_WR: begin
        row_we    = 1'b1;
        state_nxt = S_IDLE;
      end
      // posteriors start from the channel values
      S_INIT: begin
        ph_nxt = ~ph_r;
        if (ph_r) begin
          app_we    = 1'b1;
          app_wdata = APP_BITS'(llr_q);
          j_nxt     = j_r + 1'b1;
          if (last_j) begin
            j_nxt = '0; i_nxt = '0;
            have1_nxt = 1'b0; have2_nxt = 1'b0; neg_nxt = 1'b0;
            state_nxt = S_ROW_P1;
          end
        end
      end
      // first pass of a row: two smallest magnitudes and sign parity
      S_ROW_P1: begin
        ph_nxt = ~ph_r;
        if (ph_r) begin
          if (h) begin
            neg_nxt = neg_r ^ q[Q_W-1];
            if (!have1_r || qmag < min1_r) begin
              min2_nxt = min1_r; have2_nxt = have1_r;
              min1_nxt = qmag;   have1_nxt = 1'b1; idx_nxt = j_r;
            end else if (!have2_r || qmag < min2_r) begin
              min2_nxt = qmag;   have2_nxt = 1'b1;
            end
          end
          j_nxt = j_r + 1'b1;
          if (last_j) begin
            j_nxt = '0;
            if (have1_r || h) begin
              state_nxt = S_ROW_P2;
            end else if (!last_i) begin
              i_nxt = i_r + 1'b1;
              have1_nxt = 1'b0; have2_nxt = 1'b0; neg_nxt = 1'b0;
            end else if (schedule_r) begin
              i_nxt = '0;
              state_nxt = early_stop_r ? S_SYN : S_ITER_END;
              par_nxt = 1'b0;
            end else begin
              i_nxt = '0;
              state_nxt = S_COL;
            end
          end
        end
      end
      // second pass of a row: new messages, layered posterior update
      S_ROW_P2: begin
        ph_nxt = ~ph_r;
        if (ph_r) begin
          msg_we = h;
          app_we = h && schedule_r;
          j_nxt  = j_r + 1'b1;
          if (last_j) begin
            j_nxt = '0;
            have1_nxt = 1'b0; have2_nxt = 1'b0; neg_nxt = 1'b0;
            if (!last_i) begin
              i_nxt = i_r + 1'b1;
              state_nxt = S_ROW_P1;
            end else if (schedule_r) begin
              i_nxt = '0;
              par_nxt = 1'b0;
              state_nxt = early_stop_r ? S_SYN : S_ITER_END;
            end else begin
              i_nxt = '0;
              state_nxt = S_COL;
            end
          end
        end
      end
      // flooding: column sums of the messages
      S_COL: begin
        ph_nxt = ~ph_r;
        if (ph_r) begin
          acc_nxt = acc_new;
          i_nxt   = i_r + 1'b1;
          if (last_i) begin
            app_we    = 1'b1;
            app_wdata = sat_app(acc_new);
            i_nxt     = '0;
            j_nxt     = j_r + 1'b1;
            if (last_j) begin
              j_nxt = '0;
              par_nxt = 1'b0;
              state_nxt = early_stop_r ? S_SYN : S_ITER_END;
            end
          end
        end
      end
      // syndrome check over the rows, stopping at the first failing row
      S_SYN: begin
        ph_nxt = ~ph_r;
        if (ph_r) begin
          par_nxt = syn_bad;
          j_nxt   = j_r + 1'b1;
          if (last_j) begin
            j_nxt = '0;
            par_nxt = 1'b0;
            i_nxt = i_r + 1'b1;
            if (syn_bad) begin
              i_nxt = '0;
              state_nxt = S_ITER_END;
            end else if (last_i) begin
              i_nxt = '0;
              conv_nxt = 1'b1;
              state_nxt = S_ITER_END;
            end
          end
        end
      end
      S_ITER_END: begin
        iter_nxt = iter_r + 1'b1;
        i_nxt = '0;
        j_nxt = '0;
        have1_nxt = 1'b0; have2_nxt = 1'b0; neg_nxt = 1'b0;
        state_nxt = (conv_r || iter_r + 6'd1 == lim_r) ? S_HARD : S_ROW_P1;
      end
      // hard decisions
      S_HARD: begin
        ph_nxt = ~ph_r;
        if (ph_r) begin
          hard_nxt[j_r] = app_q[APP_BITS-1];
          j_nxt = j_r + 1'b1;
          if (last_j) begin
            j_nxt = '0;
            k_nxt = '0;
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (out_tready) begin
          k_nxt = k_r + 1'b1;
          if ({1'b0, k_r} + 3'd1 == nw_r) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result word
  assign out_tlast = ({1'b0, k_r} + 3'd1 == nw_r);
  assign out_tdata = {5'd0, status_r, conv_r, iter_r, hard_r[{k_r, 5'd0} +: 32], k_r};

  `LSMD_ASSERT_NOW(a_sides_exclusive, in_tready, !out_tvalid)
  `LSMD_ASSERT_NOW(a_error_zeroes, out_tvalid && status_r != ST_OK,
                   hard_r == '0 && iter_r == '0 && !conv_r)
  `LSMD_ASSERT_NOW(a_iter_bound, out_tvalid && status_r == ST_OK,
                   iter_r != '0 && iter_r <= lim_r)
  `LSMD_ASSERT_NEXT(a_llr_no_decode, in_acc && in_tuser == MODE_LLR && !in_tlast,
                    state_r == S_IDLE)
endmodule
`default_nettype wire

// ===== bench/ldpc_scaled_min_sum_decoder_checker.sv =====
// checker for the min-sum decoder: mirrors config and matrix, predicts and compares result words
`timescale 1ns / 1ps
`default_nettype none
module ldpc_scaled_min_sum_decoder_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  // row[5:0], column[12:6], h_bit[13], llr_value[21:14], zero[23:22]
  input  wire logic [23:0] in_tdata,
  // mode[0]
  input  wire logic        in_tuser,
  input  wire logic        in_tlast,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  // word_index[1:0], hard_bits[33:2], iterations_used[39:34], converged[40],
  // status[42:41], zero[47:43]
  input  wire logic [47:0] out_tdata,
  input  wire logic        out_tlast,
  output int               fail_count,
  output int               words_pending,
  output int               words_checked,
  output int               codewords_seen,
  output int               converged_seen
);
  import lsmd_pkg::*;

  typedef struct {
    logic [1:0]  word_index;
    logic [31:0] hard_bits;
    logic        final_word;
    logic [5:0]  iterations_used;
    logic        converged;
    status_t     status;
  } decision_word_t;

  localparam int NO_MAG = 1 << 20;

  decision_word_t decisions_q[$];

  // mirrored registers
  int code_len, check_cnt, iter_limit, scale_reg;
  bit early_stop_en, layered_en;

  // mirrored storage
  bit parity[M_MAX][N_MAX];
  int channel[N_MAX];
  int posterior[N_MAX];
  int message[M_MAX][N_MAX];
  int llr_count;

  assign words_pending = decisions_q.size();

  function automatic int clamp_app(int v);
    int hi;
    int lo;
    hi = (1 << (APP_BITS - 1)) - 1;
    lo = -(1 << (APP_BITS - 1));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // one check row: min-sum messages from the values before the row update
  function automatic void check_row_update(int r, int n, int scale, bit layered);
    int ext[N_MAX];
    int min1, min2, min_col, edges, mag, m;
    bit odd_neg;
    min1 = NO_MAG;
    min2 = NO_MAG;
    min_col = 0;
    edges = 0;
    odd_neg = 0;
    for (int j = 0; j < n; j++) begin
      if (!parity[r][j]) continue;
      ext[j] = posterior[j] - message[r][j];
      mag = ext[j] < 0 ? -ext[j] : ext[j];
      if (ext[j] < 0) odd_neg = !odd_neg;
      if (mag < min1) begin
        min2 = min1;
        min1 = mag;
        min_col = j;
      end else if (mag < min2) begin
        min2 = mag;
      end
      edges++;
    end
    if (edges == 0) return;
    for (int j = 0; j < n; j++) begin
      if (!parity[r][j]) continue;
      mag = (j == min_col) ? min2 : min1;
      if (mag >= NO_MAG) begin
        // lone edge gets the largest positive message
        m = (1 << (MSG_BITS - 1)) - 1;
      end else begin
        if (mag > 4096) mag = 4096;
        m = (scale * mag + 8) >>> 4;
        if (m > (1 << (MSG_BITS - 1)) - 1) m = (1 << (MSG_BITS - 1)) - 1;
        if (odd_neg != (ext[j] < 0)) m = -m;
      end
      message[r][j] = m;
      if (layered) posterior[j] = clamp_app(ext[j] + m);
    end
  endfunction

  function automatic bit syndrome_clear(int m, int n);
    bit p;
    for (int i = 0; i < m; i++) begin
      p = 0;
      for (int j = 0; j < n; j++)
        if (parity[i][j] && posterior[j] < 0) p ^= 1'b1;
      if (p) return 0;
    end
    return 1;
  endfunction

  // full decode of one codeword, queues its result words
  function automatic void decode_codeword();
    int n, m, nwords, scale, limit, iters, acc;
    bit conv;
    status_t st;
    decision_word_t w;
    n = code_len < 1 ? 1 : (code_len > N_MAX ? N_MAX : code_len);
    nwords = (n + 31) / 32;
    m = check_cnt > M_MAX ? M_MAX : check_cnt;
    iters = 0;
    conv = 0;
    if (check_cnt == 0) st = ST_NO_MATRIX;
    else if (code_len == 0 || code_len > N_MAX || llr_count != code_len) st = ST_LEN_MISMATCH;
    else st = ST_OK;
    llr_count = 0;
    if (st == ST_OK) begin
      scale = scale_reg < 2 ? 2 : (scale_reg > 16 ? 16 : scale_reg);
      limit = iter_limit < 1 ? 1 : iter_limit;
      for (int i = 0; i < M_MAX; i++)
        for (int j = 0; j < N_MAX; j++) message[i][j] = 0;
      for (int j = 0; j < n; j++) posterior[j] = channel[j];
      for (int it = 0; it < limit; it++) begin
        iters = it + 1;
        for (int i = 0; i < m; i++) check_row_update(i, n, scale, layered_en);
        if (!layered_en) begin
          for (int j = 0; j < n; j++) begin
            acc = channel[j];
            for (int i = 0; i < m; i++)
              if (parity[i][j]) acc += message[i][j];
            posterior[j] = clamp_app(acc);
          end
        end
        if (early_stop_en && syndrome_clear(m, n)) begin
          conv = 1;
          break;
        end
      end
    end
    if (conv) converged_seen++;
    for (int k = 0; k < nwords; k++) begin
      w.word_index = k[1:0];
      w.hard_bits = '0;
      if (st == ST_OK)
        for (int j = 0; j < 32 && k * 32 + j < n; j++)
          if (posterior[k * 32 + j] < 0) w.hard_bits[j] = 1'b1;
      w.final_word = (k + 1 == nwords);
      w.iterations_used = iters[5:0];
      w.converged = conv;
      w.status = st;
      decisions_q.push_back(w);
    end
    codewords_seen++;
  endfunction

  function automatic void compare_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s expected %0h got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    decision_word_t w;
    int v;
    if (!rst_n) begin
      code_len = 128;
      check_cnt = 0;
      iter_limit = 20;
      scale_reg = 12;
      early_stop_en = 1;
      layered_en = 0;
      llr_count = 0;
      for (int i = 0; i < M_MAX; i++)
        for (int j = 0; j < N_MAX; j++) parity[i][j] = 0;
    end else begin
      // register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_CODE_LENGTH: code_len = cfg_data;
          CFG_CHECK_COUNT: check_cnt = cfg_data[6:0];
          CFG_MAX_ITER:    iter_limit = cfg_data[5:0];
          CFG_SCALE:       scale_reg = cfg_data[4:0];
          CFG_EARLY_STOP:  early_stop_en = cfg_data[0];
          CFG_SCHEDULE:    layered_en = cfg_data[0];
          default: ;
        endcase
      end
      // accepted input word
      if (in_tvalid && in_tready) begin
        if (in_tuser == MODE_MATRIX) begin
          parity[in_tdata[5:0]][in_tdata[12:6]] = in_tdata[13];
        end else begin
          v = $signed(in_tdata[21:14]);
          if (llr_count < N_MAX) channel[llr_count] = v;
          if (llr_count < 255) llr_count++;
          if (in_tlast) decode_codeword();
        end
      end
      // accepted result word
      if (out_tvalid && out_tready) begin
        if (decisions_q.size() == 0) begin
          $error("result word with nothing expected: %0h", out_tdata);
          fail_count++;
        end else begin
          w = decisions_q.pop_front();
          compare_field("word_index", w.word_index, out_tdata[1:0]);
          compare_field("hard_bits", w.hard_bits, out_tdata[33:2]);
          compare_field("final_word", w.final_word, out_tlast);
          compare_field("iterations_used", w.iterations_used, out_tdata[39:34]);
          compare_field("converged", w.converged, out_tdata[40]);
          compare_field("status", w.status, out_tdata[42:41]);
          words_checked++;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== bench/tb_ldpc_scaled_min_sum_decoder.sv =====
// testbench top for the min-sum decoder: stimulus, handshake pacing and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_ldpc_scaled_min_sum_decoder;
  import lsmd_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_wr_en = 0;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 0;
  logic        in_tlast = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [47:0] out_tdata;
  logic        out_tlast;

  int fail_count, words_pending, words_checked, codewords_seen, converged_seen;
  int items_sent = 0;
  bit burst = 0;
  bit hold_req = 0;

  always #5 clk = ~clk;

  ldpc_scaled_min_sum_decoder uut (.*);

  ldpc_scaled_min_sum_decoder_checker checker_i (.*);

  // short gaps mostly, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(logic mode, logic [5:0] r, logic [6:0] c, logic hb,
                           logic [7:0] llr, logic lst);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= mode;
    in_tlast <= lst;
    in_tdata <= {2'b00, llr, hb, c, r};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic send_bit(int r, int c, bit hb);
    send_word(MODE_MATRIX, r[5:0], c[6:0], hb, 8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_llr(int v, bit lst);
    send_word(MODE_LLR, 6'($urandom), 7'($urandom), 1'($urandom), v[7:0], lst);
  endtask

  // mostly an all-zero codeword with noise, sometimes anything
  function automatic int noisy_llr();
    int v;
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 255);
    v = 24 + $urandom_range(0, 80) - 40;
    return v;
  endfunction

  task automatic send_codeword(int len);
    for (int j = 0; j < len; j++) send_llr(noisy_llr(), j == len - 1);
  endtask

  // wait until every expected word has come, plus the tail of a matrix write
  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(int cl, int cc, int it, int sc, int es, int sch);
    int vals[6];
    drain();
    vals = '{cl, cc, it, sc, es, sch};
    for (int k = 0; k < 6; k++) begin
      cfg_wr_en <= 1;
      cfg_index <= k[2:0];
      cfg_data <= vals[k][7:0];
      @(posedge clk);
    end
    cfg_wr_en <= 0;
  endtask

  // result side pacing, with one long hold on request
  initial begin
    int r;
    forever begin
      if (hold_req) begin
        out_tready <= 0;
        repeat (20000) @(posedge clk);
        hold_req = 0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          out_tready <= 0;
          repeat ($urandom_range(20, 60)) @(posedge clk);
        end else begin
          out_tready <= (r < 75) || burst;
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    int n, m, writes, len;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // no matrix set yet: status takes precedence over the length mismatch
    send_llr(-128, 0);
    send_llr(127, 0);
    send_llr(5, 1);

    // small code with a row of edges on columns 0 to 2, a lone-edge row and an empty row
    configure(8, 3, 5, 12, 1, 0);
    send_bit(0, 0, 1);
    send_bit(0, 1, 1);
    send_bit(0, 2, 1);
    send_bit(1, 3, 1);
    send_bit(63, 127, 0);
    send_llr(-128, 0);
    send_llr(127, 0);
    send_llr(0, 0);
    send_llr(-3, 0);
    send_llr(10, 0);
    send_llr(-1, 0);
    send_llr(1, 0);
    send_llr(60, 1);

    // too few samples
    send_codeword(5);

    // zero length, then a length past the limit, odd scale and iteration values
    configure(0, 3, 0, 31, 0, 1);
    send_codeword(2);
    configure(200, 3, 63, 1, 0, 1);
    send_codeword(1);

    // check count past the limit, one iteration, layered
    configure(8, 100, 1, 1, 1, 1);
    send_codeword(8);

    // one full-length codeword, flooding
    configure(128, 3, 2, 16, 1, 0);
    send_codeword(128);

    // random phases with sparse matrix edits
    for (int ph = 0; items_sent < 430; ph++) begin
      n = $urandom_range(4, 20);
      m = $urandom_range(1, 6);
      configure(n, m, $urandom_range(1, 12), $urandom_range(2, 16),
                $urandom_range(0, 1), $urandom_range(0, 1));
      burst = ($urandom_range(0, 3) == 0);
      writes = $urandom_range(4, 12);
      for (int w = 0; w < writes; w++) begin
        if ($urandom_range(0, 3) == 0) send_bit($urandom_range(0, 63), $urandom_range(0, 127),
                                                1'($urandom_range(0, 1)));
        else send_bit($urandom_range(0, m - 1), $urandom_range(0, n - 1),
                      1'($urandom_range(0, 1)));
      end
      // long result-side hold while codewords keep coming
      if (ph == 1) hold_req = 1;
      for (int cw = $urandom_range(2, 4); cw > 0; cw--) begin
        len = ($urandom_range(0, 9) == 0) ? n + $urandom_range(0, 1) * 2 - 1 : n;
        send_codeword(len);
      end
      burst = 0;
    end

    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d input words, %0d codewords, %0d result words (%0d converged)",
             items_sent, codewords_seen, words_checked, converged_seen);
    if (fail_count == 0 && words_pending == 0) begin
      $display("tb_ldpc_scaled_min_sum_decoder passed");
    end else begin
      $display("tb_ldpc_scaled_min_sum_decoder failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(50_000_000);
    $display("tb_ldpc_scaled_min_sum_decoder failed");
    $finish;
  end
endmodule
`default_nettype wire
